/* rtl/mbps_pkg.sv */
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants of the masked byte pattern scanner
// Holds the request and result payloads, the pattern configuration bundle
// handed to the compare cells, and the configuration register indexes.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned PAT_REG_BYTES = 16;
  localparam int unsigned PAT_IDX_W     = 4;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned ADDR_W        = 64;
  localparam int unsigned COUNT_W       = 7;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO  = 3'd0,
    CFG_PAT_HI  = 3'd1,
    CFG_CARE    = 3'd2,
    CFG_LEN     = 3'd3,
    CFG_BASE    = 3'd4
  } cfg_idx_e;

  // Input request: one buffer byte
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_t;

  // Result item
  typedef struct packed {
    logic               is_match;
    logic [ADDR_W-1:0]  match_address;
    logic               done_res;
    logic [COUNT_W-1:0] match_count;
  } out_t;

  // Pattern setup seen by every cell
  typedef struct packed {
    logic [PAT_REG_BYTES*BYTE_W-1:0] pattern;
    logic [PAT_REG_BYTES-1:0]        care;
    logic [LEN_W-1:0]                len;
  } pat_cfg_t;

  // Pattern byte idx out of the packed pattern vector
  function automatic logic [BYTE_W-1:0] pat_byte(
    input logic [PAT_REG_BYTES*BYTE_W-1:0] pattern,
    input logic [PAT_IDX_W-1:0]            idx
  );
    return pattern[idx*BYTE_W +: BYTE_W];
  endfunction

endpackage

/* rtl/mbps_stream_if.sv */
// ----------------------------------------------------------------------------
// mbps_stream_if: valid/ready stream channel
// Carries one payload of type T per request; a request moves on a clock
// edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface mbps_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

/* rtl/mbps_cell.sv */
// ----------------------------------------------------------------------------
// mbps_cell: one window position of the scan chain
// Holds one buffer byte, passes it to the next cell on every shift, and
// checks it against the pattern byte that lands on this position.
// ----------------------------------------------------------------------------
module mbps_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                                  clk_i,
  input  logic                                  shift_en_i,
  input  logic [mbps_pkg::BYTE_W-1:0]           byte_i,
  input  mbps_pkg::pat_cfg_t                    cfg_i,
  output logic [mbps_pkg::BYTE_W-1:0]           byte_o,
  output logic                                  ok_o
);

  logic [mbps_pkg::BYTE_W-1:0]    byte_q;
  logic [mbps_pkg::LEN_W-1:0]     pidx_full;
  logic [mbps_pkg::PAT_IDX_W-1:0] pidx;
  logic                           in_win;
  logic                           care_bit;
  logic [mbps_pkg::BYTE_W-1:0]    pbyte;

  // Window byte, no reset: only bytes of the current buffer get compared
  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      byte_q <= byte_i;
    end
  end

  // Position k from newest holds pattern byte len-1-k
  assign pidx_full = mbps_pkg::LEN_W'(cfg_i.len - mbps_pkg::LEN_W'(1)
                                      - mbps_pkg::LEN_W'(CELL_IDX));
  assign pidx      = pidx_full[mbps_pkg::PAT_IDX_W-1:0];
  assign in_win    = mbps_pkg::LEN_W'(CELL_IDX) < cfg_i.len;
  assign care_bit  = cfg_i.care[pidx];
  assign pbyte     = mbps_pkg::pat_byte(cfg_i.pattern, pidx);

  assign ok_o   = !in_win || !care_bit || (byte_q == pbyte);
  assign byte_o = byte_q;

endmodule

/* rtl/masked_byte_pattern_scan_core.sv */
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_core: streaming wildcard byte signature scanner
// Scans a buffer one byte per request through a cell chain and reports up to
// MAX_MATCHES masked matches per buffer, plus a count result on the last byte.
//
//   channel  | dir | payload                                       | kind
//   ---------+-----+-----------------------------------------------+--------
//   in_if    | in  | data_byte, last_byte                          | stream
//   out_if   | out | is_match, match_address, done_res, match_count | stream
//   cfg_*    | in  | cfg_idx_i, cfg_data_i on cfg_we_i             | write
//
// One byte is taken per cycle unless a stall holds the match stage.
// The cell chain shifts on accept, the match stage evaluates the window the
// cycle after, and the output register adds the base address.
// Stalls on out_if back up through the match stage into in_if.ready; the
// window does not shift while the match stage holds a request.
// rst_ni clears counters and config (len to 1); window bytes are not reset.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan_core #(
  parameter int unsigned PATTERN_MAX_LEN = 16,
  parameter int unsigned MAX_MATCHES     = 64,
  parameter int unsigned OFFSET_BITS     = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  mbps_stream_if.sink                         in_if,
  mbps_stream_if.source                       out_if,
  input  logic                                cfg_we_i,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned NUM_CELLS = (PATTERN_MAX_LEN < mbps_pkg::PAT_REG_BYTES)
                                      ? PATTERN_MAX_LEN : mbps_pkg::PAT_REG_BYTES;
  localparam int unsigned MF_W      = $clog2(MAX_MATCHES + 1);

  // Configuration registers
  logic [63:0]                    pat_lo_q, pat_hi_q, base_q;
  logic [15:0]                    care_q;
  logic [mbps_pkg::LEN_W-1:0]     len_q;
  mbps_pkg::pat_cfg_t             pat_cfg;

  // Offset counter and match stage
  logic [OFFSET_BITS-1:0]         offset_q, offset_d;
  logic                           s1_valid_q, s1_valid_d;
  logic                           s1_last_q, s1_live_q, s1_reached_q;
  logic [OFFSET_BITS-1:0]         s1_start_q;
  logic [MF_W-1:0]                mf_q, mf_d, mf_inc;
  logic                           len_ok, saturated, in_fire, s1_fire, s1_res;
  logic                           hit, out_free;
  logic [mbps_pkg::LEN_W-1:0]     len_m1;
  logic [MF_W+mbps_pkg::COUNT_W-1:0] cnt_ext;

  // Output register
  logic                           out_valid_q, out_valid_d;
  mbps_pkg::out_t                 out_q;

  // Cell chain wiring
  logic [mbps_pkg::BYTE_W-1:0]    chain_in  [NUM_CELLS];
  logic [mbps_pkg::BYTE_W-1:0]    chain_out [NUM_CELLS];
  logic [NUM_CELLS-1:0]           cell_ok;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      care_q   <= '0;
      len_q    <= mbps_pkg::LEN_RESET;
      base_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (mbps_pkg::cfg_idx_e'(cfg_idx_i))
        mbps_pkg::CFG_PAT_LO: pat_lo_q <= cfg_data_i;
        mbps_pkg::CFG_PAT_HI: pat_hi_q <= cfg_data_i;
        mbps_pkg::CFG_CARE:   care_q   <= cfg_data_i[15:0];
        mbps_pkg::CFG_LEN:    len_q    <= cfg_data_i[mbps_pkg::LEN_W-1:0];
        mbps_pkg::CFG_BASE:   base_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pat_cfg.pattern = {pat_hi_q, pat_lo_q};
  assign pat_cfg.care    = care_q;
  assign pat_cfg.len     = len_q;

  assign len_ok = (len_q != '0) && (int'(len_q) <= int'(mbps_pkg::PAT_REG_BYTES))
                  && (int'(len_q) <= int'(PATTERN_MAX_LEN));
  assign len_m1 = mbps_pkg::LEN_W'(len_q - mbps_pkg::LEN_W'(1));

  // Compare cell chain, newest byte in cell 0
  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign chain_in[j] = in_if.payload.data_byte;
    end else begin : g_link
      assign chain_in[j] = chain_out[j-1];
    end
    mbps_cell #(
      .CELL_IDX (j)
    ) u_cell (
      .clk_i      (clk_i),
      .shift_en_i (in_fire),
      .byte_i     (chain_in[j]),
      .cfg_i      (pat_cfg),
      .byte_o     (chain_out[j]),
      .ok_o       (cell_ok[j])
    );
  end

  // Handshake chain: output register, match stage, input
  assign out_free    = !out_valid_q || out_if.ready;
  assign hit         = s1_live_q && len_ok && s1_reached_q
                       && (mf_q < MF_W'(MAX_MATCHES)) && (&cell_ok);
  assign s1_res      = hit || s1_last_q;
  assign s1_fire     = s1_valid_q && (!s1_res || out_free);
  assign in_if.ready = !s1_valid_q || s1_fire;
  assign in_fire     = in_if.valid && in_if.ready;

  // Offset counter, saturating, cleared by the last byte
  assign saturated = &offset_q;
  always_comb begin
    offset_d = offset_q;
    if (in_fire) begin
      if (in_if.payload.last_byte) begin
        offset_d = '0;
      end else if (!saturated) begin
        offset_d = offset_q + OFFSET_BITS'(1);
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      offset_q   <= offset_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // Match stage payload: start offset and length check taken at accept
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_last_q    <= in_if.payload.last_byte;
      s1_live_q    <= !saturated;
      s1_reached_q <= offset_q >= OFFSET_BITS'(len_m1);
      s1_start_q   <= offset_q - OFFSET_BITS'(len_m1);
    end
  end

  // Per-buffer match counter
  assign mf_inc = mf_q + MF_W'(1);
  always_comb begin
    mf_d = mf_q;
    if (s1_fire) begin
      if (s1_last_q) begin
        mf_d = '0;
      end else if (hit) begin
        mf_d = mf_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mf_q <= '0;
    end else begin
      mf_q <= mf_d;
    end
  end

  // Output register: address add and count masking
  assign cnt_ext = {{mbps_pkg::COUNT_W{1'b0}}, (hit ? mf_inc : mf_q)};

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_res) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_res) begin
      out_q.is_match      <= hit;
      out_q.match_address <= hit ? (base_q + mbps_pkg::ADDR_W'(s1_start_q)) : '0;
      out_q.done_res      <= s1_last_q;
      out_q.match_count   <= cnt_ext[mbps_pkg::COUNT_W-1:0];
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

  // Checks
  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.payload.is_match || out_if.payload.done_res))
    else $error("result without match or done");

  a_no_match_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.payload.is_match) |-> (out_if.payload.match_address == '0))
    else $error("done result without match carries an address");

  a_match_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mf_q <= MF_W'(MAX_MATCHES))
    else $error("match counter above cap");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire) |-> !in_fire ##1 (s1_valid_q && $stable(s1_start_q)))
    else $error("match stage lost or shifted a held request");

endmodule
